// File: rtl/sisd_pkg.sv
// shared types and constants for the descending string sorter
package sisd_pkg;

    typedef enum logic [7:0] {
        ST_LOAD  = 8'b0000_0001,
        ST_INIT  = 8'b0000_0010,
        ST_PICK  = 8'b0000_0100,
        ST_RDORD = 8'b0000_1000,
        ST_RDCH  = 8'b0001_0000,
        ST_CMP   = 8'b0010_0000,
        ST_PLACE = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic load_byte;
        logic init_order;
        logic pick;
        logic rd_order;
        logic rd_char;
        logic cmp_step;
        logic shift;
        logic place;
        logic emit_rd;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic is_term;
        logic eos;
        logic init_done;
        logic sort_done;
        logic hole_zero;
        logic cmp_done;
        logic cmp_less;
        logic emit_last;
        logic count_zero;
    } status_t;

endpackage

// File: rtl/string_insertion_sort_desc.sv
// top level of the descending string insertion sorter
// Bytes load at one per cycle into a string store (MAX_STRINGS slots of MAX_LEN
// bytes). On the terminator carrying end_of_set the input stalls while an insertion
// sort walks the order list: the list is first filled at one entry per cycle, then
// each string compare fetches the neighbor index and then reads and compares one
// byte at a time through the single read port of the store. Each insertion begins
// with a pick and ends with a place step, and a string that reaches the front goes
// from the index fetch straight to place. Results follow the sort, one index per
// cycle while the receiver takes them; last marks the final one and overflow
// reports dropped bytes or strings.
module string_insertion_sort_desc #(
    parameter int MAX_STRINGS = 32,
    parameter int MAX_LEN     = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_byte,
    input  logic       end_of_set,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [4:0] string_index,
    output logic       last,
    output logic       overflow
);
    import sisd_pkg::*;

    cmd_t    cmd;
    status_t sts;

    // control sequencer
    sisd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // storage and compare datapath
    sisd_dp #(.MAX_STRINGS(MAX_STRINGS), .MAX_LEN(MAX_LEN)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_byte    (char_byte),
        .end_of_set   (end_of_set),
        .cmd          (cmd),
        .sts          (sts),
        .string_index (string_index),
        .last         (last),
        .overflow     (overflow)
    );
endmodule

// File: rtl/sisd_ram.sv
// generic single-write ram with registered read
module sisd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/sisd_ctrl.sv
// sequencer for load, insertion sort and emit phases
module sisd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  sisd_pkg::status_t sts,
    output sisd_pkg::cmd_t    cmd
);
    import sisd_pkg::*;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    assign in_stall  = (state_reg != ST_LOAD);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.load_byte = 1'b1;
                    if (sts.is_term && sts.eos)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                if (sts.count_zero)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    cmd.init_order = 1'b1;
                    if (sts.init_done)
                    begin
                        state_next = ST_PICK;
                    end
                end
            end
            ST_PICK:
            begin
                if (sts.sort_done)
                begin
                    cmd.emit_rd = 1'b1;
                    state_next  = ST_EMIT;
                end
                else
                begin
                    cmd.pick   = 1'b1;
                    state_next = ST_RDORD;
                end
            end
            ST_RDORD:
            begin
                if (sts.hole_zero)
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    cmd.rd_order = 1'b1;
                    state_next   = ST_RDCH;
                end
            end
            ST_RDCH:
            begin
                cmd.rd_char = 1'b1;
                state_next  = ST_CMP;
            end
            ST_CMP:
            begin
                if (sts.cmp_done)
                begin
                    if (sts.cmp_less)
                    begin
                        cmd.shift  = 1'b1;
                        state_next = ST_RDORD;
                    end
                    else
                    begin
                        state_next = ST_PLACE;
                    end
                end
                else
                begin
                    cmd.cmp_step = 1'b1;
                    state_next   = ST_RDCH;
                end
            end
            ST_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = ST_PICK;
            end
            ST_EMIT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b0;
                    if (!ov_reg || !sts.emit_last)
                    begin
                        if (ov_reg || !sts.emit_last)
                        begin
                            cmd.emit_rd = ov_reg;
                        end
                        ov_next = 1'b1;
                    end
                    else
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end
endmodule

// File: rtl/sisd_dp.sv
// datapath: string store, order list, compare walk and output register
module sisd_dp #(
    parameter int MAX_STRINGS = 32,
    parameter int MAX_LEN     = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        char_byte,
    input  logic              end_of_set,
    input  sisd_pkg::cmd_t    cmd,
    output sisd_pkg::status_t sts,
    output logic [4:0]        string_index,
    output logic              last,
    output logic              overflow
);
    import sisd_pkg::*;

    localparam int SW = $clog2(MAX_STRINGS);
    localparam int CW = $clog2(MAX_STRINGS + 1);
    localparam int LW = $clog2(MAX_LEN);
    localparam int AW = $clog2(MAX_STRINGS * MAX_LEN);

    logic [CW-1:0] count_reg;
    logic [LW-1:0] pos_reg;
    logic          drop_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] hole_reg;
    logic [SW-1:0] moving_reg;
    logic [SW-1:0] prev_reg;
    logic [LW-1:0] k_reg;
    logic [7:0]    x_reg;
    logic [SW-1:0] ord [MAX_STRINGS];
    logic [CW-1:0] e_reg;
    logic [4:0]    idx_reg;
    logic          last_reg;

    logic          full;
    logic          st_we;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [7:0]    st_rdata;
    logic [SW-1:0] rd_slot;
    logic [LW-1:0] k_addr;
    logic          lt, ne;

    assign full  = (count_reg >= CW'(MAX_STRINGS));
    assign st_we = cmd.load_byte && !full &&
                   ((char_byte == 8'd0) || (pos_reg < LW'(MAX_LEN - 1)));
    assign st_waddr = AW'(count_reg[SW-1:0]) * AW'(MAX_LEN) + AW'(pos_reg);
    // moving byte is fetched in rdord or cmp, at the position the next rdch uses
    assign k_addr   = cmd.rd_order ? '0 : (cmd.cmp_step ? k_reg + LW'(1) : k_reg);
    assign rd_slot  = cmd.rd_char ? prev_reg : moving_reg;
    assign st_raddr = AW'(rd_slot) * AW'(MAX_LEN) + AW'(k_addr);

    // alternate reads: moving byte in rdord or cmp, prev byte in rdch
    sisd_ram #(.WIDTH(8), .DEPTH(MAX_STRINGS * MAX_LEN)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (char_byte),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // in cmp: x_reg = moving byte, st_rdata = prev byte
    assign lt = st_rdata < x_reg;
    assign ne = x_reg != st_rdata;

    assign sts.is_term    = (char_byte == 8'd0);
    assign sts.eos        = end_of_set;
    assign sts.init_done  = (i_reg == count_reg - CW'(1));
    assign sts.sort_done  = (i_reg >= count_reg);
    assign sts.hole_zero  = (hole_reg == '0);
    assign sts.cmp_done   = ne || (x_reg == 8'd0) || (k_reg == LW'(MAX_LEN - 1));
    assign sts.cmp_less   = lt;
    assign sts.emit_last  = last_reg;
    assign sts.count_zero = (count_reg == '0);

    assign string_index = idx_reg;
    assign last         = last_reg;
    assign overflow     = drop_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.init_order)
        begin
            ord[i_reg[SW-1:0]] <= i_reg[SW-1:0];
        end
        if (cmd.shift)
        begin
            ord[hole_reg[SW-1:0]] <= prev_reg;
        end
        if (cmd.place)
        begin
            ord[hole_reg[SW-1:0]] <= moving_reg;
        end
        if (cmd.pick)
        begin
            moving_reg <= ord[i_reg[SW-1:0]];
        end
        if (cmd.rd_order)
        begin
            prev_reg <= ord[hole_reg[SW-1:0] - SW'(1)];
        end
        // ram output during rd_char is the moving byte read last cycle
        if (cmd.rd_char)
        begin
            x_reg <= st_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pos_reg   <= '0;
            drop_reg  <= 1'b0;
            i_reg     <= '0;
            hole_reg  <= '0;
            k_reg     <= '0;
            e_reg     <= '0;
            idx_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load_byte)
            begin
                if (char_byte != 8'd0)
                begin
                    if (full || pos_reg >= LW'(MAX_LEN - 1))
                    begin
                        drop_reg <= 1'b1;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + LW'(1);
                    end
                end
                else
                begin
                    if (full)
                    begin
                        drop_reg <= 1'b1;
                    end
                    else
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                    pos_reg <= '0;
                    i_reg   <= '0;
                end
            end
            if (cmd.init_order)
            begin
                i_reg <= sts.init_done ? CW'(1) : i_reg + CW'(1);
            end
            if (cmd.pick)
            begin
                hole_reg <= i_reg;
            end
            if (cmd.rd_order)
            begin
                k_reg <= '0;
            end
            if (cmd.cmp_step)
            begin
                k_reg <= k_reg + LW'(1);
            end
            if (cmd.shift)
            begin
                hole_reg <= hole_reg - CW'(1);
            end
            if (cmd.place)
            begin
                i_reg <= i_reg + CW'(1);
            end
            if (cmd.emit_rd)
            begin
                idx_reg  <= 5'(ord[e_reg[SW-1:0]]);
                last_reg <= (e_reg == count_reg - CW'(1));
                e_reg    <= e_reg + CW'(1);
                if (e_reg == count_reg - CW'(1))
                begin
                    count_reg <= '0;
                end
            end
            // final result taken: start a fresh set
            if (cmd.finish)
            begin
                e_reg    <= '0;
                last_reg <= 1'b0;
                drop_reg <= 1'b0;
            end
            if (cmd.init_order && count_reg != '0)
            begin
                e_reg <= '0;
            end
        end
    end
endmodule
